// File: rtl/gds_pkg.sv
package gds_pkg;

    localparam int COUNT_BITS_DEF = 16;

    // Working widths of the date registers (offset arithmetic may leave range).
    localparam int DAY_W  = 12;
    localparam int MON_W  = 12;
    localparam int YEAR_W = 16;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;

    // Action codes
    localparam logic [2:0] ACT_NEXT = 3'd0;
    localparam logic [2:0] ACT_PREV = 3'd1;
    localparam logic [2:0] ACT_ADD  = 3'd2;
    localparam logic [2:0] ACT_SUB  = 3'd3;
    localparam logic [2:0] ACT_OADD = 3'd4;
    localparam logic [2:0] ACT_OSUB = 3'd5;

    // Datapath operations
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_CLAMP = 4'd2;
    localparam logic [3:0] OP_DSTEP = 4'd3;
    localparam logic [3:0] OP_OINIT = 4'd4;
    localparam logic [3:0] OP_OSTEP = 4'd5;
    localparam logic [3:0] OP_MOFS  = 4'd6;
    localparam logic [3:0] OP_MSTEP = 4'd7;
    localparam logic [3:0] OP_YOFS  = 4'd8;
    localparam logic [3:0] OP_OUT   = 4'd9;

    localparam logic signed [MON_W-1:0] MONTHS_PER_YEAR = MON_W'(12);
    localparam logic signed [MON_W-1:0] MON_ONE         = MON_W'(1);
    localparam logic signed [DAY_W-1:0] DAY_ONE         = DAY_W'(1);

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };
    localparam logic [4:0] FEB_LEAP_LEN = 5'd29;
    localparam logic [4:0] LONG_MONTH   = 5'd31;

    // Divisibility by 25: multiply by the inverse of 25 mod 2^16 and compare.
    localparam logic [15:0] INV25     = 16'd23593;
    localparam logic [15:0] DIV25_MAX = 16'd2621;

    typedef struct packed {
        logic [3:0] op;
        logic       sub;
    } gds_cmd_t;

    typedef struct packed {
        logic leap_ok;
        logic rem_zero;
        logic day_over;
        logic day_under;
        logic mon_over;
        logic mon_under;
        logic out_busy;
    } gds_stat_t;

    function automatic logic [4:0] days_in_month(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        if (mon == 4'd2 && leap) begin
            len = FEB_LEAP_LEN;
        end else if (mon >= 4'd1 && mon <= 4'd12) begin
            len = MONTH_LEN[mon - 4'd1];
        end else begin
            len = LONG_MONTH;
        end
        return len;
    endfunction

    // 4/100/400 rule on a two's complement year; 400 = 16 * 25, 100 = 4 * 25.
    function automatic logic leap_of(input logic [YEAR_W-1:0] yr);
        logic [15:0] mag;
        logic [31:0] prod;
        logic        div25;
        mag   = yr[YEAR_W-1] ? 16'(-yr) : 16'(yr);
        prod  = 32'(mag) * 32'(INV25);
        div25 = (prod[15:0] <= DIV25_MAX);
        return ((yr[1:0] == 2'd0) && !div25) || ((yr[3:0] == 4'd0) && div25);
    endfunction

endpackage

// File: rtl/gds_ctrl.sv
module gds_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2:0]            s_action,
    input  gds_pkg::gds_stat_t    stat,
    output gds_pkg::gds_cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLAMP = 3'd1;
    localparam logic [2:0] ST_DAYS  = 3'd2;
    localparam logic [2:0] ST_OINIT = 3'd3;
    localparam logic [2:0] ST_ODAY  = 3'd4;
    localparam logic [2:0] ST_OMON  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] action_reg, action_next;
    logic       sub_reg, sub_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        action_next = action_reg;
        sub_next    = sub_reg;
        cmd.op      = gds_pkg::OP_NONE;
        cmd.sub     = sub_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op      = gds_pkg::OP_LOAD;
                    action_next = s_action;
                    sub_next    = (s_action == gds_pkg::ACT_PREV) ||
                                  (s_action == gds_pkg::ACT_SUB)  ||
                                  (s_action == gds_pkg::ACT_OSUB);
                    state_next  = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                if (stat.leap_ok) begin
                    cmd.op = gds_pkg::OP_CLAMP;
                    unique case (action_reg) inside
                        gds_pkg::ACT_NEXT, gds_pkg::ACT_PREV,
                        gds_pkg::ACT_ADD, gds_pkg::ACT_SUB:   state_next = ST_DAYS;
                        gds_pkg::ACT_OADD, gds_pkg::ACT_OSUB: state_next = ST_OINIT;
                        default:                              state_next = ST_DONE;
                    endcase
                end
            end
            ST_DAYS: begin
                if (stat.leap_ok) begin
                    if (stat.rem_zero) begin
                        state_next = ST_DONE;
                    end else begin
                        cmd.op = gds_pkg::OP_DSTEP;
                    end
                end
            end
            ST_OINIT: begin
                cmd.op     = gds_pkg::OP_OINIT;
                state_next = ST_ODAY;
            end
            ST_ODAY: begin
                if (stat.leap_ok) begin
                    if (sub_reg ? stat.day_under : stat.day_over) begin
                        cmd.op = gds_pkg::OP_OSTEP;
                    end else begin
                        cmd.op     = gds_pkg::OP_MOFS;
                        state_next = ST_OMON;
                    end
                end
            end
            ST_OMON: begin
                if (sub_reg ? stat.mon_under : stat.mon_over) begin
                    cmd.op = gds_pkg::OP_MSTEP;
                end else begin
                    cmd.op     = gds_pkg::OP_YOFS;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.leap_ok && !stat.out_busy) begin
                    cmd.op     = gds_pkg::OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        action_reg <= action_next;
        sub_reg    <= sub_next;
    end

endmodule

// File: rtl/gds_datapath.sv
module gds_datapath #(
    parameter int COUNT_BITS = gds_pkg::COUNT_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  gds_pkg::gds_cmd_t               cmd,
    input  logic [2:0]                      in_action,
    input  logic [4:0]                      in_day,
    input  logic [3:0]                      in_month,
    input  logic [13:0]                     in_year,
    input  logic [15:0]                     in_count,
    input  logic [9:0]                      in_oday,
    input  logic [9:0]                      in_omon,
    input  logic [13:0]                     in_oyear,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [gds_pkg::M_TDATA_W-1:0]   m_tdata,
    output gds_pkg::gds_stat_t              stat
);

    localparam int DW = gds_pkg::DAY_W;
    localparam int MW = gds_pkg::MON_W;
    localparam int YW = gds_pkg::YEAR_W;
    localparam int CW = (COUNT_BITS < 16) ? COUNT_BITS : 16;
    localparam int XW = ((CW > 5) ? CW : 5) + 1;

    logic signed [DW-1:0] day_reg, day_next;
    logic signed [MW-1:0] month_reg, month_next;
    logic signed [YW-1:0] year_reg, year_next;
    logic [CW-1:0]        rem_reg, rem_next;
    logic [9:0]           oday_reg, oday_next;
    logic [9:0]           omon_reg, omon_next;
    logic [13:0]          oyear_reg, oyear_next;
    logic                 valid_reg, valid_next;
    logic                 leap_reg;
    logic [YW-1:0]        leap_yr_reg;

    logic                 m_tvalid_reg;
    logic [4:0]           out_day_reg;
    logic [3:0]           out_month_reg;
    logic [YW-1:0]        out_year_reg;
    logic                 out_valid_reg, out_leap_reg, out_pos_reg;

    logic [4:0]           dim_cur;
    logic signed [DW-1:0] dim_s;
    logic [4:0]           left;
    logic [3:0]           mon_clamp;
    logic [4:0]           dim_clamp;
    logic [3:0]           mon_dec;
    logic                 leap_ok;

    assign leap_ok   = (leap_yr_reg == year_reg);
    assign dim_cur   = gds_pkg::days_in_month(month_reg[3:0], leap_reg);
    assign dim_s     = DW'(dim_cur);
    assign left      = dim_cur - day_reg[4:0];
    assign mon_clamp = (month_reg[3:0] == 4'd0) ? 4'd1 :
                       (month_reg[3:0] > 4'd12) ? 4'd12 : month_reg[3:0];
    assign dim_clamp = gds_pkg::days_in_month(mon_clamp, leap_reg);
    assign mon_dec   = (month_reg == gds_pkg::MON_ONE) ? 4'd12 : (month_reg[3:0] - 4'd1);

    assign stat.leap_ok   = leap_ok;
    assign stat.rem_zero  = (rem_reg == '0);
    assign stat.day_over  = (day_reg > dim_s);
    assign stat.day_under = (day_reg < gds_pkg::DAY_ONE);
    assign stat.mon_over  = (month_reg > gds_pkg::MONTHS_PER_YEAR);
    assign stat.mon_under = (month_reg < gds_pkg::MON_ONE);
    assign stat.out_busy  = m_tvalid_reg && !m_tready;

    always_comb begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        rem_next   = rem_reg;
        oday_next  = oday_reg;
        omon_next  = omon_reg;
        oyear_next = oyear_reg;
        valid_next = valid_reg;
        unique case (cmd.op)
            gds_pkg::OP_LOAD: begin
                day_next   = DW'(in_day);
                month_next = MW'(in_month);
                year_next  = YW'(in_year);
                oday_next  = in_oday;
                omon_next  = in_omon;
                oyear_next = in_oyear;
                if (in_action == gds_pkg::ACT_NEXT || in_action == gds_pkg::ACT_PREV) begin
                    rem_next = CW'(1);
                end else begin
                    rem_next = in_count[CW-1:0];
                end
            end
            gds_pkg::OP_CLAMP: begin
                valid_next = (day_reg[4:0] != 5'd0) && (month_reg[3:0] >= 4'd1) &&
                             (month_reg[3:0] <= 4'd12) && (day_reg[4:0] <= dim_clamp) &&
                             (year_reg != '0);
                month_next = MW'(mon_clamp);
                if (day_reg[4:0] == 5'd0) begin
                    day_next = gds_pkg::DAY_ONE;
                end else if (day_reg[4:0] > dim_clamp) begin
                    day_next = DW'(dim_clamp);
                end
            end
            gds_pkg::OP_DSTEP: begin
                if (!cmd.sub) begin
                    // walk forward one month or finish inside this month
                    if (XW'(rem_reg) <= XW'(left)) begin
                        day_next = day_reg + DW'(rem_reg);
                        rem_next = '0;
                    end else begin
                        rem_next = rem_reg - CW'(left) - CW'(1);
                        day_next = gds_pkg::DAY_ONE;
                        if (month_reg == gds_pkg::MONTHS_PER_YEAR) begin
                            month_next = gds_pkg::MON_ONE;
                            year_next  = year_reg + YW'(1);
                        end else begin
                            month_next = month_reg + gds_pkg::MON_ONE;
                        end
                    end
                end else begin
                    // borrow the whole current month, land on last day of previous, or finish inside this month
                    if (XW'(rem_reg) < XW'(day_reg[4:0])) begin
                        day_next = day_reg - DW'(rem_reg);
                        rem_next = '0;
                    end else begin
                        rem_next   = rem_reg - CW'(day_reg[4:0]);
                        month_next = MW'(mon_dec);
                        day_next   = DW'(gds_pkg::days_in_month(mon_dec, leap_reg));
                        if (month_reg == gds_pkg::MON_ONE) begin
                            year_next = year_reg - YW'(1);
                        end
                    end
                end
            end
            gds_pkg::OP_OINIT: begin
                day_next = cmd.sub ? (day_reg - DW'(oday_reg)) : (day_reg + DW'(oday_reg));
            end
            gds_pkg::OP_OSTEP: begin
                if (!cmd.sub) begin
                    day_next = day_reg - dim_s;
                    if (month_reg == gds_pkg::MONTHS_PER_YEAR) begin
                        month_next = gds_pkg::MON_ONE;
                        year_next  = year_reg + YW'(1);
                    end else begin
                        month_next = month_reg + gds_pkg::MON_ONE;
                    end
                end else begin
                    day_next   = day_reg + dim_s;
                    month_next = MW'(mon_dec);
                    if (month_reg == gds_pkg::MON_ONE) begin
                        year_next = year_reg - YW'(1);
                    end
                end
            end
            gds_pkg::OP_MOFS: begin
                month_next = cmd.sub ? (month_reg - MW'(omon_reg)) : (month_reg + MW'(omon_reg));
            end
            gds_pkg::OP_MSTEP: begin
                if (!cmd.sub) begin
                    month_next = month_reg - gds_pkg::MONTHS_PER_YEAR;
                    year_next  = year_reg + YW'(1);
                end else begin
                    month_next = month_reg + gds_pkg::MONTHS_PER_YEAR;
                    year_next  = year_reg - YW'(1);
                end
            end
            gds_pkg::OP_YOFS: begin
                year_next = cmd.sub ? (year_reg - YW'(oyear_reg)) : (year_reg + YW'(oyear_reg));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            year_reg     <= '0;
            leap_yr_reg  <= '0;
            leap_reg     <= 1'b1;
        end else begin
            if (cmd.op == gds_pkg::OP_OUT) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            year_reg    <= year_next;
            // leap flag is registered from the year, so it trails it; leap_ok tells when it is current
            leap_yr_reg <= year_reg;
            leap_reg    <= gds_pkg::leap_of(year_reg);
        end
        day_reg   <= day_next;
        month_reg <= month_next;
        rem_reg   <= rem_next;
        oday_reg  <= oday_next;
        omon_reg  <= omon_next;
        oyear_reg <= oyear_next;
        valid_reg <= valid_next;
        if (cmd.op == gds_pkg::OP_OUT) begin
            out_day_reg   <= day_reg[4:0];
            out_month_reg <= month_reg[3:0];
            out_year_reg  <= year_reg;
            out_valid_reg <= valid_reg;
            out_leap_reg  <= leap_reg;
            out_pos_reg   <= !year_reg[YW-1] && (year_reg != '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, out_pos_reg, out_leap_reg, out_valid_reg,
                       out_year_reg, out_month_reg, out_day_reg};

endmodule

// File: rtl/gregorian_date_stepper_top.sv
// Channel  Direction  Ports                          Payload
// s_       in         s_tvalid s_tready s_tdata      date, day count, offset
//                     s_tuser                        action
// m_       out        m_tvalid m_tready m_tdata      result date and flags
//
// After a transfer in, day actions run a clamp step, month-loop steps (a step crosses a
// month or ends the walk), a loop exit and an output load; offset actions run a clamp,
// a day add, a step per month crossed, a step per year carried, two loop exits, a load.
// A leap-dependent step waits after a year change (a new input year counts) until the
// leap flag is current; the load waits while the last result is not taken. One item is in
// work at a time; s_tready returns as the result loads, even while m_tready is low.
module gregorian_date_stepper_top #(
    parameter int COUNT_BITS = gds_pkg::COUNT_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // start_day[4:0] start_month[8:5] start_year[22:9] day_count[38:23]
    // offset_day[48:39] offset_month[58:49] offset_year[72:59], zero fill
    input  logic [gds_pkg::S_TDATA_W-1:0]   s_tdata,
    // action[2:0]
    input  logic [gds_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // result_day[4:0] result_month[8:5] result_year[24:9] input_valid[25]
    // result_leap[26] year_positive[27], zero fill
    output logic [gds_pkg::M_TDATA_W-1:0]   m_tdata
);

    gds_pkg::gds_cmd_t  cmd;
    gds_pkg::gds_stat_t stat;

    // Sequencer: decides which datapath step runs in each cycle.
    gds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_action (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Date registers, remaining-day counter, leap unit and output register.
    gds_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_action (s_tuser),
        .in_day    (s_tdata[4:0]),
        .in_month  (s_tdata[8:5]),
        .in_year   (s_tdata[22:9]),
        .in_count  (s_tdata[38:23]),
        .in_oday   (s_tdata[48:39]),
        .in_omon   (s_tdata[58:49]),
        .in_oyear  (s_tdata[72:59]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .stat      (stat)
    );

    // After a transfer in, hold off further input until the result is produced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in work");

    // A new result is loaded only as the sequencer returns to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == gds_pkg::OP_OUT) |=> (m_tvalid && s_tready))
        else $error("result load did not return sequencer to idle");

    // Every result month is normalized.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8:5] >= 4'd1 && m_tdata[8:5] <= 4'd12))
        else $error("result month out of range");

endmodule
